// ===== rtl/core/jbt_pkg.sv =====
// JSON byte tokenizer: shared types, character codes and the literal letter table.
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none
package jbt_pkg;

   typedef enum logic [3:0] {
      MODE_START      = 4'd0,
      MODE_STR        = 4'd1,
      MODE_ESC        = 4'd2,
      MODE_HEX        = 4'd3,
      MODE_NEG        = 4'd4,
      MODE_INT        = 4'd5,
      MODE_FRAC_FIRST = 4'd6,
      MODE_FRAC       = 4'd7,
      MODE_EXP_FIRST  = 4'd8,
      MODE_EXP_SIGNED = 4'd9,
      MODE_EXP        = 4'd10,
      MODE_LIT        = 4'd11
   } mode_type;

   typedef enum logic [1:0] {
      KIND_CHAR  = 2'd0,
      KIND_END   = 2'd1,
      KIND_ERROR = 2'd2,
      KIND_EOI   = 2'd3
   } kind_type;

   typedef enum logic [2:0] {
      TT_ARRAY_START  = 3'd0,
      TT_OBJECT_START = 3'd1,
      TT_ARRAY_END    = 3'd2,
      TT_OBJECT_END   = 3'd3,
      TT_STRING       = 3'd4,
      TT_NUMBER       = 3'd5,
      TT_NULL         = 3'd6,
      TT_BOOLEAN      = 3'd7
   } token_kind_type;

   typedef struct packed {
      kind_type       kind;
      logic [7:0]     ch;
      token_kind_type ttype;
      logic           last;
   } result_type;

   typedef struct packed {
      mode_type   mode;
      logic [2:0] hex_left;
      logic [3:0] lit_prog;
   } lex_state_type;

   localparam lex_state_type START_STATE = '{MODE_START, 3'd0, 4'd0};

   localparam int QDEPTH = 4;

   localparam logic [7:0] CH_SPACE  = 8'h20;
   localparam logic [7:0] CH_TAB    = 8'h09;
   localparam logic [7:0] CH_CR     = 8'h0D;
   localparam logic [7:0] CH_LF     = 8'h0A;
   localparam logic [7:0] CH_COLON  = 8'h3A;
   localparam logic [7:0] CH_COMMA  = 8'h2C;
   localparam logic [7:0] CH_LBRACK = 8'h5B;
   localparam logic [7:0] CH_RBRACK = 8'h5D;
   localparam logic [7:0] CH_LBRACE = 8'h7B;
   localparam logic [7:0] CH_RBRACE = 8'h7D;
   localparam logic [7:0] CH_QUOTE  = 8'h22;
   localparam logic [7:0] CH_BSLASH = 8'h5C;
   localparam logic [7:0] CH_SLASH  = 8'h2F;
   localparam logic [7:0] CH_MINUS  = 8'h2D;
   localparam logic [7:0] CH_PLUS   = 8'h2B;
   localparam logic [7:0] CH_DOT    = 8'h2E;
   localparam logic [7:0] CH_LO_E   = 8'h65;
   localparam logic [7:0] CH_UP_E   = 8'h45;
   localparam logic [7:0] CH_LO_U   = 8'h75;
   localparam logic [7:0] CH_LO_B   = 8'h62;
   localparam logic [7:0] CH_LO_F   = 8'h66;
   localparam logic [7:0] CH_LO_N   = 8'h6E;
   localparam logic [7:0] CH_LO_R   = 8'h72;
   localparam logic [7:0] CH_LO_T   = 8'h74;

   // null, true, false back to back; index is the literal progress
   function automatic logic [7:0] lit_char(input logic [3:0] p);
      logic [7:0] c;
      unique case (p)
         4'd0:    c = "n";
         4'd1:    c = "u";
         4'd2:    c = "l";
         4'd3:    c = "l";
         4'd4:    c = "t";
         4'd5:    c = "r";
         4'd6:    c = "u";
         4'd7:    c = "e";
         4'd8:    c = "f";
         4'd9:    c = "a";
         4'd10:   c = "l";
         4'd11:   c = "s";
         4'd12:   c = "e";
         default: c = 8'h00;
      endcase
      return c;
   endfunction

endpackage
`default_nettype wire

// ===== rtl/core/jbt_if.sv =====
// JSON byte tokenizer: valid/ready channel interfaces for request and response words.
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none
interface jbt_req_if;
   logic       valid;
   logic       ready;
   logic [7:0] in_byte;
   logic       end_of_input;

   modport source (output valid, output in_byte, output end_of_input, input ready);
   modport sink (input valid, input in_byte, input end_of_input, output ready);
endinterface

interface jbt_rsp_if;
   logic       valid;
   logic       ready;
   logic [1:0] result_kind;
   logic [7:0] token_char;
   logic [2:0] token_type;
   logic       last_of_run;

   modport source (output valid, output result_kind, output token_char,
                   output token_type, output last_of_run, input ready);
   modport sink (input valid, input result_kind, input token_char,
                 input token_type, input last_of_run, output ready);
endinterface
`default_nettype wire

// ===== rtl/core/jbt_step.sv =====
// JSON byte tokenizer: combinational lexer step, one byte or end mark in, up to two results.
// Depends on jbt_pkg.
`timescale 1ns / 1ps
`default_nettype none
module jbt_step
   import jbt_pkg::*;
(
   input  wire logic [7:0]    in_byte,
   input  wire logic          end_of_input,
   input  wire lex_state_type cur,
   output lex_state_type      nxt,
   output logic [1:0]         count,
   output result_type         res0,
   output result_type         res1
);

   typedef struct packed {
      logic          emit;
      result_type    res;
      lex_state_type st;
   } start_type;

   function automatic result_type mk(input kind_type k, input logic [7:0] c,
                                     input token_kind_type t);
      result_type r;
      r.kind  = k;
      r.ch    = c;
      r.ttype = t;
      r.last  = 1'b0;
      return r;
   endfunction

   function automatic logic is_digit(input logic [7:0] c);
      return (c >= "0") && (c <= "9");
   endfunction

   function automatic logic is_hex(input logic [7:0] c);
      return is_digit(c) || ((c >= "a") && (c <= "f")) || ((c >= "A") && (c <= "F"));
   endfunction

   function automatic start_type start_token(input logic [7:0] c);
      start_type s;
      s.emit = 1'b1;
      s.res  = mk(KIND_CHAR, c, TT_ARRAY_START);
      s.st   = START_STATE;
      unique case (c)
         CH_SPACE, CH_TAB, CH_CR, CH_LF, CH_COLON, CH_COMMA: begin
            s.emit = 1'b0;
         end
         CH_LBRACK: s.res = mk(KIND_END, 8'h00, TT_ARRAY_START);
         CH_LBRACE: s.res = mk(KIND_END, 8'h00, TT_OBJECT_START);
         CH_RBRACK: s.res = mk(KIND_END, 8'h00, TT_ARRAY_END);
         CH_RBRACE: s.res = mk(KIND_END, 8'h00, TT_OBJECT_END);
         CH_QUOTE: begin
            s.emit    = 1'b0;
            s.st.mode = MODE_STR;
         end
         CH_MINUS: s.st.mode = MODE_NEG;
         CH_LO_N: begin
            s.st.mode     = MODE_LIT;
            s.st.lit_prog = 4'd1;
         end
         CH_LO_T: begin
            s.st.mode     = MODE_LIT;
            s.st.lit_prog = 4'd5;
         end
         CH_LO_F: begin
            s.st.mode     = MODE_LIT;
            s.st.lit_prog = 4'd9;
         end
         default: begin
            if (is_digit(c)) begin
               s.st.mode = MODE_INT;
            end else begin
               s.res = mk(KIND_ERROR, 8'h00, TT_ARRAY_START);
            end
         end
      endcase
      return s;
   endfunction

   start_type  st;
   result_type r0;
   result_type r1;
   logic [1:0] n;
   logic [7:0] c;
   result_type err_r;
   result_type chr_r;

   always_comb begin
      c     = in_byte;
      st    = start_token(c);
      err_r = mk(KIND_ERROR, 8'h00, TT_ARRAY_START);
      chr_r = mk(KIND_CHAR, c, TT_ARRAY_START);
      nxt   = cur;
      n     = 2'd0;
      r0    = chr_r;
      r1    = mk(KIND_EOI, 8'h00, TT_ARRAY_START);
      if (end_of_input) begin
         nxt = START_STATE;
         unique case (cur.mode)
            MODE_START: begin
               n  = 2'd1;
               r0 = mk(KIND_EOI, 8'h00, TT_ARRAY_START);
            end
            MODE_STR: begin
               n  = 2'd2;
               r0 = mk(KIND_END, 8'h00, TT_STRING);
            end
            MODE_INT, MODE_FRAC, MODE_EXP: begin
               n  = 2'd2;
               r0 = mk(KIND_END, 8'h00, TT_NUMBER);
            end
            MODE_ESC, MODE_HEX, MODE_NEG, MODE_FRAC_FIRST, MODE_EXP_FIRST,
            MODE_EXP_SIGNED, MODE_LIT: begin
               n  = 2'd2;
               r0 = err_r;
            end
            default: begin
               n  = 2'd1;
               r0 = mk(KIND_EOI, 8'h00, TT_ARRAY_START);
            end
         endcase
      end else begin
         unique case (cur.mode)
            MODE_STR: begin
               n = 2'd1;
               if (c == CH_QUOTE) begin
                  r0  = mk(KIND_END, 8'h00, TT_STRING);
                  nxt = START_STATE;
               end else if (c == CH_BSLASH) begin
                  nxt.mode = MODE_ESC;
               end
            end
            MODE_ESC: begin
               n = 2'd1;
               unique case (c)
                  CH_QUOTE, CH_BSLASH, CH_SLASH, CH_LO_B, CH_LO_F, CH_LO_N,
                  CH_LO_R, CH_LO_T: nxt.mode = MODE_STR;
                  CH_LO_U: begin
                     nxt.mode     = MODE_HEX;
                     nxt.hex_left = 3'd4;
                  end
                  default: begin
                     r0  = err_r;
                     nxt = START_STATE;
                  end
               endcase
            end
            MODE_HEX: begin
               n = 2'd1;
               if (!is_hex(c)) begin
                  r0  = err_r;
                  nxt = START_STATE;
               end else if (cur.hex_left <= 3'd1) begin
                  nxt.hex_left = 3'd0;
                  nxt.mode     = MODE_STR;
               end else begin
                  nxt.hex_left = cur.hex_left - 3'd1;
               end
            end
            MODE_NEG, MODE_FRAC_FIRST, MODE_EXP_SIGNED: begin
               n = 2'd1;
               if (!is_digit(c)) begin
                  r0  = err_r;
                  nxt = START_STATE;
               end else if (cur.mode == MODE_NEG) begin
                  nxt.mode = MODE_INT;
               end else if (cur.mode == MODE_FRAC_FIRST) begin
                  nxt.mode = MODE_FRAC;
               end else begin
                  nxt.mode = MODE_EXP;
               end
            end
            MODE_EXP_FIRST: begin
               n = 2'd1;
               if (is_digit(c)) begin
                  nxt.mode = MODE_EXP;
               end else if ((c == CH_PLUS) || (c == CH_MINUS)) begin
                  nxt.mode = MODE_EXP_SIGNED;
               end else begin
                  r0  = err_r;
                  nxt = START_STATE;
               end
            end
            MODE_INT, MODE_FRAC, MODE_EXP: begin
               priority if (is_digit(c)) begin
                  n = 2'd1;
               end else if ((c == CH_DOT) && (cur.mode == MODE_INT)) begin
                  n        = 2'd1;
                  nxt.mode = MODE_FRAC_FIRST;
               end else if (((c == CH_LO_E) || (c == CH_UP_E)) && (cur.mode != MODE_EXP)) begin
                  n        = 2'd1;
                  nxt.mode = MODE_EXP_FIRST;
               end else begin
                  // number ends; this byte starts the next token
                  r0  = mk(KIND_END, 8'h00, TT_NUMBER);
                  r1  = st.res;
                  n   = 2'd1 + {1'b0, st.emit};
                  nxt = st.st;
               end
            end
            MODE_LIT: begin
               if ((cur.lit_prog < 4'd13) && (c == lit_char(cur.lit_prog))) begin
                  if (cur.lit_prog == 4'd3) begin
                     n   = 2'd2;
                     r1  = mk(KIND_END, 8'h00, TT_NULL);
                     nxt = START_STATE;
                  end else if ((cur.lit_prog == 4'd7) || (cur.lit_prog == 4'd12)) begin
                     n   = 2'd2;
                     r1  = mk(KIND_END, 8'h00, TT_BOOLEAN);
                     nxt = START_STATE;
                  end else begin
                     n            = 2'd1;
                     nxt.lit_prog = cur.lit_prog + 4'd1;
                  end
               end else begin
                  n   = 2'd1;
                  r0  = err_r;
                  nxt = START_STATE;
               end
            end
            default: begin
               n   = {1'b0, st.emit};
               r0  = st.res;
               nxt = st.st;
            end
         endcase
      end
      r0.last = (n == 2'd1);
      r1.last = (n == 2'd2);
   end

   assign count = n;
   assign res0  = r0;
   assign res1  = r1;

endmodule
`default_nettype wire

// ===== rtl/core/json_byte_tokenizer_core.sv =====
// JSON byte tokenizer top level: input stage, lexer state, four-word result queue.
// Depends on jbt_pkg, jbt_if and jbt_step.
//
//   channel  dir  word contents
//   req_if   in   in_byte[7:0], end_of_input
//   rsp_if   out  result_kind[1:0], token_char[7:0], token_type[2:0], last_of_run
//
// One byte per cycle is taken while req_if.ready is high; each byte yields zero,
// one or two result words. Results leave one per cycle while rsp_if.ready is high,
// from a four-entry register queue. The stage register feeds the lexer step,
// which advances only when the queue has room for two words.
// Synchronous reset returns the lexer to token start and empties the queue.
`timescale 1ns / 1ps
`default_nettype none
module json_byte_tokenizer_core
   import jbt_pkg::*;
(
   input  wire logic clock,
   input  wire logic reset,
   jbt_req_if.sink   req_if,
   jbt_rsp_if.source rsp_if
);

   logic          stg_valid_ff;
   logic          stg_valid_in;
   logic [7:0]    stg_byte_ff;
   logic          stg_eoi_ff;
   lex_state_type lex_ff;
   lex_state_type lex_in;
   result_type    q_ff [QDEPTH];
   logic [1:0]    wr_ptr_ff;
   logic [1:0]    wr_ptr_in;
   logic [1:0]    rd_ptr_ff;
   logic [1:0]    rd_ptr_in;
   logic [2:0]    count_ff;
   logic [2:0]    count_in;

   lex_state_type step_nxt;
   logic [1:0]    step_n;
   result_type    step_r0;
   result_type    step_r1;
   logic          advance;
   logic          pop;
   logic [1:0]    push_n;
   logic          take;
   result_type    head;

   jbt_step u_step (
      .in_byte      (stg_byte_ff),
      .end_of_input (stg_eoi_ff),
      .cur          (lex_ff),
      .nxt          (step_nxt),
      .count        (step_n),
      .res0         (step_r0),
      .res1         (step_r1)
   );

   assign advance      = stg_valid_ff && (count_ff <= 3'(QDEPTH - 2));
   assign req_if.ready = !stg_valid_ff || advance;
   assign take         = req_if.valid && req_if.ready;
   assign pop          = (count_ff != 3'd0) && rsp_if.ready;
   assign push_n       = advance ? step_n : 2'd0;

   always_comb begin
      stg_valid_in = take ? 1'b1 : (advance ? 1'b0 : stg_valid_ff);
      lex_in       = advance ? step_nxt : lex_ff;
      wr_ptr_in    = wr_ptr_ff + push_n;
      rd_ptr_in    = rd_ptr_ff + {1'b0, pop};
      count_in     = count_ff + {1'b0, push_n} - {2'b00, pop};
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         stg_valid_ff <= 1'b0;
         lex_ff       <= START_STATE;
         wr_ptr_ff    <= 2'd0;
         rd_ptr_ff    <= 2'd0;
         count_ff     <= 3'd0;
      end else begin
         stg_valid_ff <= stg_valid_in;
         lex_ff       <= lex_in;
         wr_ptr_ff    <= wr_ptr_in;
         rd_ptr_ff    <= rd_ptr_in;
         count_ff     <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (take) begin
         stg_byte_ff <= req_if.in_byte;
         stg_eoi_ff  <= req_if.end_of_input;
      end
      if (push_n != 2'd0) begin
         q_ff[wr_ptr_ff] <= step_r0;
      end
      if (push_n == 2'd2) begin
         q_ff[wr_ptr_ff + 2'd1] <= step_r1;
      end
   end

   assign head               = q_ff[rd_ptr_ff];
   assign rsp_if.valid       = (count_ff != 3'd0);
   assign rsp_if.result_kind = head.kind;
   assign rsp_if.token_char  = head.ch;
   assign rsp_if.token_type  = head.ttype;
   assign rsp_if.last_of_run = head.last;

   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      count_ff <= 3'(QDEPTH))
      else $error("result queue overfilled");

   a_eoi_reports: assert property (@(posedge clock) disable iff (reset)
      (advance && stg_eoi_ff) |->
         (step_n != 2'd0) &&
         (((step_n == 2'd1) && (step_r0.kind == KIND_EOI)) ||
          ((step_n == 2'd2) && (step_r1.kind == KIND_EOI))))
      else $error("end of input without end-of-input word");

   a_eoi_restart: assert property (@(posedge clock) disable iff (reset)
      (advance && stg_eoi_ff) |=> (lex_ff.mode == MODE_START))
      else $error("lexer not at token start after end of input");

   a_last_flag: assert property (@(posedge clock) disable iff (reset)
      (push_n == 2'd2) |-> (!step_r0.last && step_r1.last))
      else $error("last-of-run flag on wrong word");

endmodule
`default_nettype wire
